### design/ctp_pkg.sv
package ctp_pkg;

  localparam int SET_SIZE_MAX  = 256;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_LEN      = 24;
  localparam int PRESCALE      = 14;
  localparam int CORDIC_ITERS  = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  // square root of a 32-bit sum whose top bit pair is never both set: 16 digit steps
  localparam int SQRT_STEPS    = 16;
  localparam int RUN_LEN       = (CORDIC_ITERS > SQRT_STEPS) ? CORDIC_ITERS : SQRT_STEPS;
  localparam int ITER_W        = $clog2(RUN_LEN);
  localparam int POS_W         = 8;
  localparam int LAST_POS      = (SET_SIZE_MAX < 256) ? (SET_SIZE_MAX - 1) : 255;
  localparam int CORDIC_W      = 34;

  localparam logic [31:0] SQRT_BIT_INIT = 32'h4000_0000;
  localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [32:0] ROUND_HALF    = 33'h0_0000_8000;
  localparam logic [15:0] PHASE_ZERO    = 16'd0;
  localparam logic [15:0] PHASE_QUARTER = 16'd16384;
  localparam logic [15:0] PHASE_HALF    = 16'd32768;
  localparam logic [15:0] PHASE_3QUART  = 16'd49152;
  localparam logic [16:0] RANK_NONE     = 17'h1_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } ctp_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              commit;
    logic [ITER_W-1:0] iter;
  } ctp_cmd_t;

  typedef struct packed {
    logic [15:0]      magnitude;
    logic [15:0]      phase_turns;
    logic             phase_valid;
    logic [15:0]      max_magnitude;
    logic [POS_W-1:0] max_position;
    logic [POS_W-1:0] min_phase_position;
  } ctp_result_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10680862;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### design/ctp_in_if.sv
interface ctp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] real_part;
  logic signed [15:0] imag_part;
  logic               start_set;

  modport source (output valid, output real_part, output imag_part, output start_set,
                  input ready);
  modport sink   (input valid, input real_part, input imag_part, input start_set,
                  output ready);
endinterface

### design/ctp_out_if.sv
interface ctp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] magnitude;
  logic [15:0] phase_turns;
  logic        phase_valid;
  logic [15:0] max_magnitude;
  logic [7:0]  max_position;
  logic [7:0]  min_phase_position;

  modport source (output valid, output magnitude, output phase_turns, output phase_valid,
                  output max_magnitude, output max_position, output min_phase_position,
                  input ready);
  modport sink   (input valid, input magnitude, input phase_turns, input phase_valid,
                  input max_magnitude, input max_position, input min_phase_position,
                  output ready);
endinterface

### design/ctp_ctrl.sv
module ctp_ctrl
  import ctp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctp_cmd_t cmd
);

  ctp_state_t        state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      iter      <= iter_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    iter_next  = iter;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.commit = 1'b0;
    cmd.iter   = iter;
    case (state)
      ST_IDLE: begin
        // no sample beat while in reset
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          iter_next  = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step  = 1'b1;
        iter_next = iter + 1'b1;
        if (iter == ITER_W'(RUN_LEN - 1)) begin
          iter_next  = '0;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // wait for the output register to be free
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    out_valid_next = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : out_valid);
  end

endmodule

### design/ctp_datapath.sv
module ctp_datapath
  import ctp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  ctp_cmd_t           cmd,
  input  logic signed [15:0] real_part,
  input  logic signed [15:0] imag_part,
  input  logic               start_set,
  output ctp_result_t        result
);

  // held sample
  logic signed [15:0] re, im;
  logic               start;

  // cordic
  logic signed [CORDIC_W-1:0] x, y;
  logic [31:0]                acc;
  logic signed [CORDIC_W-1:0] sx, sy;
  logic [31:0]                atan_v;
  logic                       cordic_on;

  // square root
  logic [31:0] rem, root, bitv;
  logic [32:0] trial;
  logic        sqrt_on;

  // running best values
  logic [POS_W-1:0] set_position;
  logic [15:0]      best_mag;
  logic [POS_W-1:0] best_mag_pos;
  logic [16:0]      best_phase;
  logic [POS_W-1:0] best_phase_pos;

  logic signed [31:0]         re_sq, im_sq;
  logic signed [CORDIC_W-1:0] re_w, im_w;
  logic [32:0]                acc_round;
  logic [15:0]                phase, mag;
  logic                       valid;
  logic [16:0]                rank;
  logic [POS_W-1:0]           idx;
  logic                       win_mag, win_phase;
  logic [15:0]                best_mag_next;
  logic [POS_W-1:0]           best_mag_pos_next;
  logic [16:0]                best_phase_next;
  logic [POS_W-1:0]           best_phase_pos_next;

  assign re_sq = real_part * real_part;
  assign im_sq = imag_part * imag_part;
  assign re_w  = CORDIC_W'(real_part) <<< PRESCALE;
  assign im_w  = CORDIC_W'(imag_part) <<< PRESCALE;

  assign sx        = x >>> cmd.iter;
  assign sy        = y >>> cmd.iter;
  assign atan_v    = atan_turn(5'(cmd.iter));
  assign cordic_on = {1'b0, cmd.iter} < (ITER_W + 1)'(CORDIC_ITERS);
  assign sqrt_on   = {1'b0, cmd.iter} < (ITER_W + 1)'(SQRT_STEPS);
  assign trial     = {1'b0, root} + {1'b0, bitv};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re    <= real_part;
      im    <= imag_part;
      start <= start_set;
      // quadrant pre-rotation into the right half plane
      if (real_part[15]) begin
        x   <= -re_w;
        y   <= -im_w;
        acc <= TURN_HALF;
      end else begin
        x   <= re_w;
        y   <= im_w;
        acc <= '0;
      end
      rem  <= unsigned'(re_sq) + unsigned'(im_sq);
      root <= '0;
      bitv <= SQRT_BIT_INIT;
    end else if (cmd.step) begin
      if (cordic_on) begin
        if (!y[CORDIC_W-1]) begin
          x   <= x + sy;
          y   <= y - sx;
          acc <= acc + atan_v;
        end else begin
          x   <= x - sy;
          y   <= y + sx;
          acc <= acc - atan_v;
        end
      end
      if (sqrt_on) begin
        if ({1'b0, rem} >= trial) begin
          rem  <= rem - trial[31:0];
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
    end
  end

  always_comb begin
    acc_round = {1'b0, acc} + ROUND_HALF;
    valid     = 1'b1;
    if (re == 16'sd0 && im == 16'sd0) begin
      valid = 1'b0;
      phase = PHASE_ZERO;
    end else if (im == 16'sd0) begin
      phase = re[15] ? PHASE_HALF : PHASE_ZERO;
    end else if (re == 16'sd0) begin
      phase = im[15] ? PHASE_3QUART : PHASE_QUARTER;
    end else begin
      phase = acc_round[31:16];
    end
    // remainder above the root means the true root is past the half step
    mag  = root[15:0] + 16'(rem > root);
    rank = valid ? ({1'b0, phase} + 17'd1) : 17'd0;
    idx  = start ? '0 : set_position;

    win_mag   = start || (mag > best_mag);
    win_phase = start || (rank < best_phase);

    best_mag_next       = win_mag ? mag : best_mag;
    best_mag_pos_next   = win_mag ? idx : best_mag_pos;
    best_phase_next     = win_phase ? rank : best_phase;
    best_phase_pos_next = win_phase ? idx : best_phase_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_position   <= '0;
      best_mag       <= '0;
      best_mag_pos   <= '0;
      best_phase     <= RANK_NONE;
      best_phase_pos <= '0;
    end else if (cmd.commit) begin
      set_position   <= (idx < POS_W'(LAST_POS)) ? (idx + 1'b1) : POS_W'(LAST_POS);
      best_mag       <= best_mag_next;
      best_mag_pos   <= best_mag_pos_next;
      best_phase     <= best_phase_next;
      best_phase_pos <= best_phase_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result.magnitude          <= mag;
      result.phase_turns        <= phase;
      result.phase_valid        <= valid;
      result.max_magnitude      <= best_mag_next;
      result.max_position       <= best_mag_pos_next;
      result.min_phase_position <= best_phase_pos_next;
    end
  end

endmodule

### design/cartesian_to_polar_tracker.sv
// cartesian to polar converter with per-set best tracking
// sample channel: one beat carries real_part, imag_part (signed 16-bit) and
//   start_set; start_set opens a new set and restarts the position count
// result channel: one beat per sample with magnitude, phase_turns (1/65536
//   turn), phase_valid (low for the zero vector), and the running largest
//   magnitude with its position and the position of the smallest phase
// conversion: a shared iteration loop does one cordic rotation and one
//   square root digit per cycle, then the finish step rounds, handles the
//   axis cases and does the best compare as it commits the result
// a new sample is taken only once the last one is committed; sample ready
//   is high only while the loop is idle
// the result sits in an output register, so a new sample is taken while the
//   last result still waits; if the receiver stalls past the end of the next
//   conversion, that conversion holds in its final step until the register
//   frees up
// reset: sample ready goes high as soon as rst drops, no result is
//   pending, and the best values start as if a set had just begun
module cartesian_to_polar_tracker
  import ctp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  ctp_in_if.sink   sample,
  ctp_out_if.source result
);

  ctp_cmd_t    cmd;
  ctp_result_t res;

  // sequencer: load, iteration count, commit into the output register
  ctp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // cordic, square root, set trackers and result register
  ctp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .real_part (sample.real_part),
    .imag_part (sample.imag_part),
    .start_set (sample.start_set),
    .result    (res)
  );

  assign result.magnitude          = res.magnitude;
  assign result.phase_turns        = res.phase_turns;
  assign result.phase_valid        = res.phase_valid;
  assign result.max_magnitude      = res.max_magnitude;
  assign result.max_position       = res.max_position;
  assign result.min_phase_position = res.min_phase_position;

endmodule

### bench/testbench.sv
module testbench
  import ctp_pkg::*;
();

  // run length guard, far above the slowest legal run of about 450 samples
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 14;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 412;
  localparam int LONG_SET_LEN = 280;

  // atan(2^-i) in 2^-32 turn units, stage 0 in the low word
  localparam logic [24*32-1:0] ARC_STEPS = {
    32'd81,       32'd163,      32'd326,      32'd652,
    32'd1304,     32'd2608,     32'd5215,     32'd10430,
    32'd20861,    32'd41722,    32'd83443,    32'd166886,
    32'd333772,   32'd667544,   32'd1335087,  32'd2670163,
    32'd5340245,  32'd10680862, 32'd21354465, 32'd42667331,
    32'd85004756, 32'd167458907, 32'd316933406, 32'd536870912
  };

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               start;
  } sample_t;

  logic clk;
  logic rst;

  ctp_in_if  sample_if ();
  ctp_out_if result_if ();

  cartesian_to_polar_tracker dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_if),
    .result (result_if)
  );

  always #6 clk = ~clk;

  sample_t     pending_samples[$];
  ctp_result_t expected_results[$];
  ctp_result_t oldest_result;

  // running best values of the current set
  logic [POS_W-1:0] set_slot;
  logic [16:0]      top_magnitude;
  logic [POS_W-1:0] top_magnitude_slot;
  logic [16:0]      lowest_rank;
  logic [POS_W-1:0] lowest_rank_slot;

  int error_count;
  int cycle_count;
  int items_offered;
  int results_seen;
  int hold_left;
  bit hold_done;
  bit beat_taken;
  int prev_re;
  int prev_im;

  // floor root by bit trial, then round to nearest
  function automatic logic [15:0] rounded_root(longint unsigned sum);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sum) root = trial;
    end
    if (sum > root * root + root) root++;
    return root[15:0];
  endfunction

  // quadrant fold into the right half plane, then vectoring rotations
  function automatic logic [15:0] cordic_turns(longint re, longint im);
    longint      x;
    longint      y;
    longint      nx;
    longint      ny;
    logic [31:0] acc;
    logic [32:0] rounded;
    x   = re;
    y   = im;
    acc = '0;
    if (x < 0) begin
      x   = -x;
      y   = -y;
      acc = TURN_HALF;
    end
    x = x <<< PRESCALE;
    y = y <<< PRESCALE;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      // residual at or above zero turns clockwise and adds the step angle
      if (y >= 0) begin
        nx  = x + (y >>> i);
        ny  = y - (x >>> i);
        acc = acc + ARC_STEPS[i*32 +: 32];
      end else begin
        nx  = x - (y >>> i);
        ny  = y + (x >>> i);
        acc = acc - ARC_STEPS[i*32 +: 32];
      end
      x = nx;
      y = ny;
    end
    // rounding past the last code wraps to zero turn
    rounded = {1'b0, acc} + ROUND_HALF;
    return rounded[31:16];
  endfunction

  // polar conversion plus per-set tracking of one accepted sample
  function automatic ctp_result_t convert_and_track(sample_t s);
    ctp_result_t      r;
    longint           re;
    longint           im;
    logic [16:0]      rank;
    logic [POS_W-1:0] slot;
    re = s.re;
    im = s.im;
    r.magnitude   = rounded_root(longint'(re * re + im * im));
    r.phase_valid = 1'b1;
    r.phase_turns = PHASE_ZERO;
    if (re == 0 && im == 0) r.phase_valid = 1'b0;
    else if (im == 0) r.phase_turns = (re > 0) ? PHASE_ZERO : PHASE_HALF;
    else if (re == 0) r.phase_turns = (im > 0) ? PHASE_QUARTER : PHASE_3QUART;
    else r.phase_turns = cordic_turns(re, im);
    // undefined phase ranks below every defined one
    rank = r.phase_valid ? {1'b0, r.phase_turns} + 17'd1 : 17'd0;
    if (s.start) begin
      set_slot           = '0;
      top_magnitude      = '0;
      top_magnitude_slot = '0;
      lowest_rank        = RANK_NONE;
      lowest_rank_slot   = '0;
    end
    slot = set_slot;
    // strict compares, so ties keep the earlier slot
    if (s.start || {1'b0, r.magnitude} > top_magnitude) begin
      top_magnitude      = {1'b0, r.magnitude};
      top_magnitude_slot = slot;
    end
    if (s.start || rank < lowest_rank) begin
      lowest_rank      = rank;
      lowest_rank_slot = slot;
    end
    // position saturates at the last slot of an overlong set
    set_slot = (slot < LAST_POS) ? slot + 1'b1 : POS_W'(LAST_POS);
    r.max_magnitude      = top_magnitude[15:0];
    r.max_position       = top_magnitude_slot;
    r.min_phase_position = lowest_rank_slot;
    return r;
  endfunction

  task automatic add_sample(input int re, input int im, input bit start);
    sample_t s;
    s.re    = re[15:0];
    s.im    = im[15:0];
    s.start = start;
    pending_samples.push_back(s);
  endtask

  function automatic int edge_value();
    case ($urandom_range(3))
      0:       return -32768;
      1:       return 32767;
      2:       return -1;
      default: return 1;
    endcase
  endfunction

  // random content, weighted toward corners, axes, zero vectors and ties
  task automatic add_random(input bit start);
    int pick;
    int re;
    int im;
    pick = $urandom_range(99);
    re   = int'($urandom_range(65535)) - 32768;
    im   = int'($urandom_range(65535)) - 32768;
    if (pick < 55) begin
    end else if (pick < 70) begin
      re = int'($urandom_range(128)) - 64;
      im = int'($urandom_range(128)) - 64;
    end else if (pick < 78) begin
      if ($urandom_range(1)) re = 0;
      else im = 0;
    end else if (pick < 83) begin
      re = 0;
      im = 0;
    end else if (pick < 90) begin
      re = prev_re;
      im = prev_im;
    end else if (pick < 95) begin
      re = edge_value();
      im = edge_value();
    end else begin
      im = $urandom_range(1) ? re : -re;
    end
    prev_re = re;
    prev_im = im;
    add_sample(re, im, start);
  endtask

  // sample driver: new beat at the falling edge, valid held until taken
  always @(negedge clk) begin
    sample_t next_sample;
    if (rst) begin
      sample_if.valid <= 1'b0;
    end else if (!sample_if.valid || beat_taken) begin
      beat_taken = 1'b0;
      // quiet stretch with no sender gaps
      if (pending_samples.size() != 0 &&
          ((items_offered >= 150 && items_offered < 260) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        next_sample = pending_samples.pop_front();
        sample_if.valid     <= 1'b1;
        sample_if.real_part <= next_sample.re;
        sample_if.imag_part <= next_sample.im;
        sample_if.start_set <= next_sample.start;
        items_offered++;
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, one long hold-off, one stall-free stretch
  always @(negedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_if.ready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 60) begin
      // long hold-off so the output register fills and sample ready drops
      hold_done = 1'b1;
      hold_left = 90;
      result_if.ready <= 1'b0;
    end else if (results_seen >= 200 && results_seen < 300) begin
      result_if.ready <= 1'b1;
    end else begin
      result_if.ready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // predict on each sample beat, check each result beat against the oldest
  always @(posedge clk) begin
    sample_t taken;
    if (!rst) begin
      if (sample_if.valid && sample_if.ready) begin
        taken.re    = sample_if.real_part;
        taken.im    = sample_if.imag_part;
        taken.start = sample_if.start_set;
        expected_results.push_back(convert_and_track(taken));
        beat_taken = 1'b1;
      end
      if (result_if.valid && result_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, magnitude %0d phase %0d",
                   $time, result_if.magnitude, result_if.phase_turns);
          error_count++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("magnitude", oldest_result.magnitude, result_if.magnitude);
          check_field("phase_turns", oldest_result.phase_turns, result_if.phase_turns);
          check_field("phase_valid", oldest_result.phase_valid, result_if.phase_valid);
          check_field("max_magnitude", oldest_result.max_magnitude,
                      result_if.max_magnitude);
          check_field("max_position", oldest_result.max_position, result_if.max_position);
          check_field("min_phase_position", oldest_result.min_phase_position,
                      result_if.min_phase_position);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int random_count;
    int set_len;
    clk = 1'b0;
    rst = 1'b1;
    sample_if.valid     = 1'b0;
    sample_if.real_part = '0;
    sample_if.imag_part = '0;
    sample_if.start_set = 1'b0;
    result_if.ready     = 1'b0;
    error_count   = 0;
    cycle_count   = 0;
    items_offered = 0;
    results_seen  = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    beat_taken    = 1'b0;
    prev_re       = 0;
    prev_im       = 0;
    set_slot           = '0;
    top_magnitude      = '0;
    top_magnitude_slot = '0;
    lowest_rank        = RANK_NONE;
    lowest_rank_slot   = '0;

    // directed: no start after reset, zero vector first
    add_sample(0, 0, 0);
    // the four axes at full scale
    add_sample(32767, 0, 0);
    add_sample(0, 32767, 0);
    add_sample(-32768, 0, 0);
    add_sample(0, -32768, 0);
    // largest magnitude, then an exact tie
    add_sample(-32768, -32768, 0);
    add_sample(-32768, -32768, 0);
    // just below a full turn, rounds up and wraps to zero
    add_sample(32767, -1, 0);
    // new set, then a wrapped phase tying with slot zero
    add_sample(1, 0, 1);
    add_sample(32767, -1, 0);
    add_sample(0, 0, 0);
    // unit diagonals in every quadrant
    add_sample(1, 1, 0);
    add_sample(-1, 1, 0);
    add_sample(-1, -1, 0);
    add_sample(1, -1, 0);
    // corners
    add_sample(32767, 32767, 0);
    add_sample(-32768, 32767, 0);
    add_sample(32767, -32768, 0);
    // new set on the negative real axis, then both sides of a half turn
    add_sample(-1, 0, 1);
    add_sample(-32768, 1, 0);
    add_sample(-32768, -1, 0);
    // set opening on a zero vector, zero tie, then a plain sample
    add_sample(0, 0, 1);
    add_sample(0, 0, 0);
    add_sample(12345, -23456, 0);

    // one set long enough to saturate the position
    add_random(1);
    for (int i = 1; i < LONG_SET_LEN; i++) add_random(0);
    random_count = LONG_SET_LEN;
    // short sets of random length after that
    while (random_count < RANDOM_ITEMS) begin
      set_len = $urandom_range(30, 1);
      add_random(1);
      for (int i = 1; i < set_len; i++) add_random(0);
      random_count += set_len;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every sample to go out and every result to come back
    while (pending_samples.size() != 0 || sample_if.valid || expected_results.size() != 0)
      @(posedge clk);
    // catch stray result beats past the pipeline latency
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      error_count += expected_results.size();
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
